[design/qtr_pkg.sv]
`default_nettype none

package qtr_pkg;

  // accumulator and result widths
  localparam int ACC_W    = 64;
  localparam int OUT_W    = 48;
  localparam int NUM_COEF = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FINISH_TIME = 3'd7;

  // reset values before truncation to the configured widths
  localparam logic [63:0] COEF_RST [NUM_COEF] = '{
    64'd0,
    64'd0,
    64'd0,
    64'd3515385000,
    64'hFFFF_FFFF_ED83_0378,
    64'd7298377
  };
  localparam logic [63:0] START_RST  = 64'd0;
  localparam logic [63:0] FINISH_RST = 64'd655360;

  // accumulator clamp limits
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] POS_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // control carried alongside each sample down the chain
  typedef struct packed {
    logic valid;
    logic sat;
    logic zero;
  } qtr_ctl_t;

endpackage

`default_nettype wire

[design/quintic_trajectory_reference_core.sv]
`default_nettype none

// Quintic trajectory reference: each beat on in_ carries a signed Q16.16 time
// sample and yields one beat on out_ with the signed Q16.32 position
// c5*dt^5 + ... + c0 (Q8.40 coefficients) and a saturation flag in out_tuser.
// dt is the time since start_time, held at finish_time - start_time from the
// finish time on; samples before start_time give position 0, flag 0. The
// block takes one sample per cycle; it registers the dt select, the split
// 64 x dt multiply, round and clamp and coefficient add of each of the five
// Horner steps, and the final rounding. in_tready drops only when the whole
// chain is full and out_tready is low. The user writes coefficients and times
// through cfg_ only while no sample is in flight; the block does not check it.
module quintic_trajectory_reference_core #(
  parameter int TIME_WIDTH = 32,
  parameter int COEF_WIDTH = 48
) (
  input  wire         clk,
  input  wire         rst_n,
  // sample channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [((TIME_WIDTH+7)/8)*8-1:0] in_tdata,  // sample_time
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,                      // position
  output logic        out_tuser,                      // saturated
  // configuration channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [qtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [((COEF_WIDTH > TIME_WIDTH) ? COEF_WIDTH : TIME_WIDTH)-1:0] cfg_data
);

  localparam int DT_W  = TIME_WIDTH + 1;
  localparam int NCOEF = qtr_pkg::NUM_COEF;
  localparam int NSTEP = NCOEF - 1;

  // configuration registers
  logic signed [COEF_WIDTH-1:0] coef_r [NCOEF];
  logic signed [TIME_WIDTH-1:0] start_time_r;
  logic signed [TIME_WIDTH-1:0] finish_time_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= qtr_pkg::COEF_RST[i][COEF_WIDTH-1:0];
      end
      start_time_r  <= qtr_pkg::START_RST[TIME_WIDTH-1:0];
      finish_time_r <= qtr_pkg::FINISH_RST[TIME_WIDTH-1:0];
    end else if (cfg_valid) begin
      if (cfg_index < qtr_pkg::CFG_IDX_W'(NCOEF)) begin
        coef_r[cfg_index] <= cfg_data[COEF_WIDTH-1:0];
      end else if (cfg_index == qtr_pkg::CFG_START_TIME) begin
        start_time_r <= cfg_data[TIME_WIDTH-1:0];
      end else if (cfg_index == qtr_pkg::CFG_FINISH_TIME) begin
        finish_time_r <= cfg_data[TIME_WIDTH-1:0];
      end
    end
  end

  // chain links: index 0 is the front stage, index NSTEP the last step
  qtr_pkg::qtr_ctl_t       ch_ctl [NCOEF];
  logic signed [63:0]      ch_acc [NCOEF];
  logic signed [DT_W-1:0]  ch_dt  [NCOEF];
  logic                    ch_rdy [NCOEF];

  // front stage: elapsed time select
  qtr_pkg::qtr_ctl_t       f_ctl_r;
  logic signed [63:0]      f_acc_r;
  logic signed [DT_W-1:0]  f_dt_r;
  logic signed [TIME_WIDTH-1:0] s;
  logic                    early, after, en_f;
  logic signed [DT_W-1:0]  dt_nxt;

  assign s      = in_tdata[TIME_WIDTH-1:0];
  assign early  = s < start_time_r;
  assign after  = s >= finish_time_r;
  assign dt_nxt = early ? '0
                : (after ? DT_W'(finish_time_r) - DT_W'(start_time_r)
                         : DT_W'(s) - DT_W'(start_time_r));
  assign en_f      = !f_ctl_r.valid || ch_rdy[0];
  assign in_tready = en_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_ctl_r <= '0;
    end else if (en_f) begin
      f_ctl_r <= '{valid: in_tvalid, sat: 1'b0, zero: early};
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      f_acc_r <= 64'(coef_r[NCOEF-1]);
      f_dt_r  <= dt_nxt;
    end
  end

  assign ch_ctl[0] = f_ctl_r;
  assign ch_acc[0] = f_acc_r;
  assign ch_dt[0]  = f_dt_r;

  // horner steps, highest coefficient first
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    qtr_horner_cell #(
      .DT_W       (DT_W),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .i_ctl  (ch_ctl[k]),
      .i_acc  (ch_acc[k]),
      .i_dt   (ch_dt[k]),
      .o_rdy  (ch_rdy[k]),
      .i_coef (coef_r[NCOEF-2-k]),
      .o_ctl  (ch_ctl[k+1]),
      .o_acc  (ch_acc[k+1]),
      .o_dt   (ch_dt[k+1]),
      .i_adv  (ch_rdy[k+1])
    );
  end

  // output stage: Q.40 to Q.32 round half up, clamp to 48 bits
  logic               out_valid_r;
  logic signed [47:0] pos_r;
  logic               sat_r;
  logic               en_o;
  logic signed [56:0] pos_full;
  logic               pos_fits;
  logic signed [47:0] pos_nxt;
  logic               sat_nxt;
  logic signed [63:0] acc_last;

  assign acc_last = ch_acc[NSTEP];
  assign pos_full = $signed({acc_last[63], acc_last[63:8]}) + $signed({56'd0, acc_last[7]});
  assign pos_fits = (&pos_full[56:47]) || !(|pos_full[56:47]);
  assign pos_nxt  = ch_ctl[NSTEP].zero ? '0
                  : (pos_fits ? pos_full[47:0]
                     : (pos_full[56] ? qtr_pkg::POS_MIN : qtr_pkg::POS_MAX));
  assign sat_nxt  = !ch_ctl[NSTEP].zero && (ch_ctl[NSTEP].sat || !pos_fits);
  assign en_o     = !out_valid_r || out_tready;
  assign ch_rdy[NSTEP] = en_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= ch_ctl[NSTEP].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      pos_r <= pos_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pos_r;
  assign out_tuser  = sat_r;

  // a sample before the start time leaves as a clean zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en_o && ch_ctl[NSTEP].valid && ch_ctl[NSTEP].zero |=>
      out_tvalid && out_tdata == '0 && !out_tuser)
    else $error("pre-start sample not zero");

  // an unclamped final value is never flagged by the output stage alone
  a_outsat: assert property (@(posedge clk) disable iff (!rst_n)
    en_o && ch_ctl[NSTEP].valid && !ch_ctl[NSTEP].sat && pos_fits |=> !out_tuser)
    else $error("spurious saturation flag");

endmodule

`default_nettype wire

[design/qtr_horner_cell.sv]
`default_nettype none

module qtr_horner_cell #(
  parameter int DT_W       = 33,
  parameter int COEF_WIDTH = 48
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // upstream side
  input  wire qtr_pkg::qtr_ctl_t        i_ctl,
  input  wire logic signed [63:0]       i_acc,
  input  wire logic signed [DT_W-1:0]   i_dt,
  output logic                          o_rdy,
  // coefficient added by this step
  input  wire logic signed [COEF_WIDTH-1:0] i_coef,
  // downstream side
  output qtr_pkg::qtr_ctl_t             o_ctl,
  output logic signed [63:0]            o_acc,
  output logic signed [DT_W-1:0]        o_dt,
  input  wire                           i_adv
);

  localparam int LO_W = 33 + DT_W;
  localparam int HI_W = 32 + DT_W;
  localparam int PW   = 64 + DT_W;
  localparam int SH_W = PW - 16;

  // stage a: partial products
  qtr_pkg::qtr_ctl_t         ctl_a_r;
  logic signed [LO_W-1:0]    pp_lo_r;
  logic signed [HI_W-1:0]    pp_hi_r;
  logic signed [DT_W-1:0]    dt_a_r;
  // stage b: scaled product
  qtr_pkg::qtr_ctl_t         ctl_b_r;
  logic signed [63:0]        prod_r;
  logic signed [DT_W-1:0]    dt_b_r;
  // stage c: accumulator out
  qtr_pkg::qtr_ctl_t         ctl_c_r;
  logic signed [63:0]        acc_c_r;
  logic signed [DT_W-1:0]    dt_c_r;

  logic en_a, en_b, en_c;

  // stage advance chain, bubbles collapse
  assign en_c  = !ctl_c_r.valid || i_adv;
  assign en_b  = !ctl_b_r.valid || en_c;
  assign en_a  = !ctl_a_r.valid || en_b;
  assign o_rdy = en_a;

  // split multiply: unsigned low half and signed high half of the accumulator
  logic signed [LO_W-1:0] pp_lo_nxt;
  logic signed [HI_W-1:0] pp_hi_nxt;
  assign pp_lo_nxt = $signed({1'b0, i_acc[31:0]}) * i_dt;
  assign pp_hi_nxt = $signed(i_acc[63:32]) * i_dt;

  // recombine, round half up, scale by 2^-16 and clamp
  logic signed [PW-1:0]   full;
  logic signed [SH_W-1:0] sh;
  logic                   fits;
  logic signed [63:0]     prod_nxt;
  assign full = $signed({pp_hi_r, 32'd0}) + PW'(pp_lo_r)
              + $signed({{(PW-16){1'b0}}, 1'b1, 15'd0});
  assign sh   = full[PW-1:16];
  assign fits = (&sh[SH_W-1:63]) || !(|sh[SH_W-1:63]);
  assign prod_nxt = fits ? sh[63:0]
                  : (sh[SH_W-1] ? qtr_pkg::ACC_MIN : qtr_pkg::ACC_MAX);

  // coefficient add with clamp
  logic signed [64:0] sum;
  logic               ovf;
  logic signed [63:0] acc_nxt;
  assign sum     = 65'(prod_r) + 65'(i_coef);
  assign ovf     = sum[64] != sum[63];
  assign acc_nxt = ovf ? (sum[64] ? qtr_pkg::ACC_MIN : qtr_pkg::ACC_MAX) : sum[63:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      if (en_a) begin
        ctl_a_r <= i_ctl;
      end
      if (en_b) begin
        ctl_b_r <= '{valid: ctl_a_r.valid,
                     sat:   ctl_a_r.sat || !fits,
                     zero:  ctl_a_r.zero};
      end
      if (en_c) begin
        ctl_c_r <= '{valid: ctl_b_r.valid,
                     sat:   ctl_b_r.sat || ovf,
                     zero:  ctl_b_r.zero};
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en_a) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
      dt_a_r  <= i_dt;
    end
    if (en_b) begin
      prod_r <= prod_nxt;
      dt_b_r <= dt_a_r;
    end
    if (en_c) begin
      acc_c_r <= acc_nxt;
      dt_c_r  <= dt_b_r;
    end
  end

  assign o_ctl = ctl_c_r;
  assign o_acc = acc_c_r;
  assign o_dt  = dt_c_r;

  // a held result stays put while downstream stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_c_r.valid && !i_adv |=> ctl_c_r.valid && $stable(acc_c_r))
    else $error("horner step result changed while stalled");

  // a product clamp marks the sample and yields a limit value
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    en_b && ctl_a_r.valid && !fits |=>
      ctl_b_r.sat && (prod_r == qtr_pkg::ACC_MAX || prod_r == qtr_pkg::ACC_MIN))
    else $error("product clamp not flagged");

  // the saturation mark is never dropped on the way through
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    en_c && ctl_b_r.valid && ctl_b_r.sat |=> ctl_c_r.sat)
    else $error("saturation mark lost");

endmodule

`default_nettype wire
